// ===== design/sdf_rm_pkg.sv =====
`default_nettype none
package sdf_rm_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEFAULT = 16;

    // Field widths of the ports.
    localparam int COORD_W = 24;
    localparam int DIR_W   = 18;
    localparam int TRAV_W  = 23;
    localparam int STEP_W  = 8;
    localparam int THR_W   = 16;
    localparam int MAT_W   = 2;
    localparam int CFG_W   = 23;
    localparam int CIDX_W  = 2;

    // Internal working widths: distances, accumulated t, sum of squares.
    localparam int DIST_W = 28;
    localparam int T_W    = 36;
    localparam int SQ_W   = 2 * DIST_W;

    // Saturation value of the accumulated distance.
    localparam logic [TRAV_W-1:0] T_MAX = {TRAV_W{1'b1}};

    // Register indexes of the configuration port.
    localparam logic [CIDX_W-1:0] REG_STEP_LIMIT = 2'd0;
    localparam logic [CIDX_W-1:0] REG_DIST_LIMIT = 2'd1;
    localparam logic [CIDX_W-1:0] REG_SURF_THR   = 2'd2;

endpackage
`default_nettype wire

// ===== design/sdf_scene_ray_marcher.sv =====
`default_nettype none
// A result follows its input transaction after step_count march iterations,
// where step_count is the number of march iterations run (at most step_limit); each
// iteration runs four lengths through the shared bit-serial square root
// and the shared multiplier. A stalled output register holds the sequencer until it drains.
// Throughput: one ray at a time; the input is ready only while the sequencer is idle.
// Reset (synchronous, active low) clears the sequencer and output valid and loads
// step_limit 100, distance_limit 3276800 and surface_threshold 66.
module sdf_scene_ray_marcher #(
    parameter int FRAC_BITS = sdf_rm_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [sdf_rm_pkg::CIDX_W-1:0]       i_cfg_index,
    input  wire logic [sdf_rm_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [sdf_rm_pkg::COORD_W-1:0] i_origin_x,
    input  wire logic signed [sdf_rm_pkg::COORD_W-1:0] i_origin_y,
    input  wire logic signed [sdf_rm_pkg::COORD_W-1:0] i_origin_z,
    input  wire logic signed [sdf_rm_pkg::DIR_W-1:0]   i_dir_x,
    input  wire logic signed [sdf_rm_pkg::DIR_W-1:0]   i_dir_y,
    input  wire logic signed [sdf_rm_pkg::DIR_W-1:0]   i_dir_z,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic                                     o_hit,
    output logic [sdf_rm_pkg::TRAV_W-1:0]            o_travel,
    output logic signed [sdf_rm_pkg::COORD_W-1:0]    o_point_x,
    output logic signed [sdf_rm_pkg::COORD_W-1:0]    o_point_y,
    output logic signed [sdf_rm_pkg::COORD_W-1:0]    o_point_z,
    output logic [sdf_rm_pkg::MAT_W-1:0]             o_material
);
    import sdf_rm_pkg::*;

    localparam int PROD_W = T_W + DIST_W;

    // Scene constants rounded to nearest at FRAC_BITS.
    localparam longint L_ONE  = (longint'(1) <<< FRAC_BITS);
    localparam longint L_1P5  = ((longint'(3) <<< FRAC_BITS) + 1) / 2;
    localparam longint L_2P5  = ((longint'(5) <<< FRAC_BITS) + 1) / 2;
    localparam longint L_0P5  = ((longint'(1) <<< FRAC_BITS) + 1) / 2;
    localparam longint L_0P7  = ((longint'(7) <<< FRAC_BITS) + 5) / 10;
    localparam longint L_0P8  = ((longint'(4) <<< FRAC_BITS) + 2) / 5;
    localparam longint L_0P6  = ((longint'(3) <<< FRAC_BITS) + 2) / 5;
    localparam longint L_0P25 = ((longint'(1) <<< FRAC_BITS) + 2) / 4;

    localparam logic signed [DIST_W-1:0] C_ONE  = DIST_W'(L_ONE);
    localparam logic signed [DIST_W-1:0] C_1P5  = DIST_W'(L_1P5);
    localparam logic signed [DIST_W-1:0] C_2P5  = DIST_W'(L_2P5);
    localparam logic signed [DIST_W-1:0] C_0P5  = DIST_W'(L_0P5);
    localparam logic signed [DIST_W-1:0] C_0P7  = DIST_W'(L_0P7);
    localparam logic signed [DIST_W-1:0] C_0P8  = DIST_W'(L_0P8);
    localparam logic signed [DIST_W-1:0] C_0P6  = DIST_W'(L_0P6);
    localparam logic signed [DIST_W-1:0] C_0P25 = DIST_W'(L_0P25);

    localparam logic signed [PROD_W-1:0] P_MIN = -(PROD_W'(64'sd8388608));
    localparam logic signed [PROD_W-1:0] P_MAX = PROD_W'(64'sd8388607);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_CHK  = 11'b000_0000_0010,
        S_PMUL = 11'b000_0000_0100,
        S_PADD = 11'b000_0000_1000,
        S_PREP = 11'b000_0001_0000,
        S_SQ   = 11'b000_0010_0000,
        S_ACC  = 11'b000_0100_0000,
        S_SQRT = 11'b000_1000_0000,
        S_POST = 11'b001_0000_0000,
        S_UPD  = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        JOB_SPHERE = 2'd0,
        JOB_BOX    = 2'd1,
        JOB_RING   = 2'd2,
        JOB_TUBE   = 2'd3
    } t_job;

    t_state r_state;
    t_job   r_job;
    logic [1:0] r_idx;

    // Configuration registers.
    logic [STEP_W-1:0] r_step_limit;
    logic [TRAV_W-1:0] r_dist_limit;
    logic [THR_W-1:0]  r_surf_thr;

    // Ray and march state.
    logic signed [COORD_W-1:0] r_o [3];
    logic signed [DIR_W-1:0]   r_d [3];
    logic signed [COORD_W-1:0] r_p [3];
    logic signed [T_W-1:0]     r_t;
    logic [STEP_W-1:0]         r_iter;
    logic signed [DIST_W-1:0]  r_q [3];
    logic signed [DIST_W-1:0]  r_rx;
    logic signed [DIST_W-1:0]  r_ry;
    logic signed [DIST_W-1:0]  r_ring;
    logic signed [DIST_W-1:0]  r_best;
    logic [MAT_W-1:0]          r_mat;
    logic                      r_hit;
    logic signed [PROD_W-1:0]  r_prod;
    logic [SQ_W-1:0]           r_acc;

    // Output register.
    logic                      r_out_valid;
    logic                      r_out_hit;
    logic [TRAV_W-1:0]         r_out_travel;
    logic signed [COORD_W-1:0] r_out_p [3];
    logic [MAT_W-1:0]          r_out_mat;

    logic                      w_in_acc;
    logic signed [T_W-1:0]     w_mul_a;
    logic signed [DIST_W-1:0]  w_mul_b;
    logic signed [DIST_W-1:0]  w_sq_op;
    logic signed [PROD_W-1:0]  w_psum;
    logic signed [COORD_W-1:0] w_psat;
    logic signed [DIST_W-1:0]  w_x;
    logic signed [DIST_W-1:0]  w_y;
    logic signed [DIST_W-1:0]  w_z;
    logic signed [DIST_W-1:0]  w_ax;
    logic signed [DIST_W-1:0]  w_ay;
    logic signed [DIST_W-1:0]  w_root;
    logic signed [DIST_W-1:0]  w_qmax;
    logic signed [DIST_W-1:0]  w_dist;
    logic signed [T_W:0]       w_tsum;
    logic signed [T_W-1:0]     w_tnext;
    logic                      w_near;
    logic                      w_sqrt_start;
    logic                      w_sqrt_done;
    logic [SQ_W-1:0]           w_sqrt_in;
    logic [SQ_W/2-1:0]         w_sqrt_root;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Shared multiplier operands: dir times t, or a square.
    always_comb begin
        w_sq_op = '0;
        unique case (r_job)
            JOB_SPHERE: w_sq_op = DIST_W'(r_p[r_idx]);
            JOB_BOX:    w_sq_op = (r_q[r_idx] < 0) ? '0 : r_q[r_idx];
            JOB_RING: begin
                if (r_idx == 2'd0)      w_sq_op = r_rx;
                else if (r_idx == 2'd2) w_sq_op = DIST_W'(r_p[2]);
                else                    w_sq_op = '0;
            end
            JOB_TUBE: begin
                if (r_idx == 2'd0)      w_sq_op = r_ring;
                else if (r_idx == 2'd1) w_sq_op = r_ry;
                else                    w_sq_op = '0;
            end
            default: w_sq_op = '0;
        endcase
        if (r_state == S_PMUL) begin
            w_mul_a = r_t;
            w_mul_b = DIST_W'(r_d[r_idx]);
        end else begin
            w_mul_a = T_W'(w_sq_op);
            w_mul_b = w_sq_op;
        end
    end

    // Point coordinate: origin plus floored product, saturated.
    always_comb begin
        w_psum = PROD_W'(r_o[r_idx]) + (r_prod >>> FRAC_BITS);
        if (w_psum < P_MIN)      w_psat = COORD_W'(P_MIN);
        else if (w_psum > P_MAX) w_psat = COORD_W'(P_MAX);
        else                     w_psat = COORD_W'(w_psum);
    end

    // Offsets of the point for the box and the torus.
    assign w_x  = DIST_W'(r_p[0]);
    assign w_y  = DIST_W'(r_p[1]);
    assign w_z  = DIST_W'(r_p[2]);
    assign w_ax = w_x - C_2P5;
    assign w_ay = w_y + C_0P5;

    // Distance of the finished length job.
    assign w_root = DIST_W'(w_sqrt_root);
    always_comb begin
        w_qmax = r_q[0];
        if (r_q[1] > w_qmax) w_qmax = r_q[1];
        if (r_q[2] > w_qmax) w_qmax = r_q[2];
        if (w_qmax > 0)      w_qmax = '0;
        unique case (r_job)
            JOB_SPHERE: w_dist = w_root - C_ONE;
            JOB_BOX:    w_dist = w_root + w_qmax;
            JOB_RING:   w_dist = w_root - C_0P6;
            JOB_TUBE:   w_dist = w_root - C_0P25;
            default:    w_dist = w_root;
        endcase
    end

    // Advance t by the nearest distance, saturating high.
    always_comb begin
        w_tsum = (T_W+1)'(r_t) + (T_W+1)'(r_best);
        if (w_tsum > (T_W+1)'(T_MAX)) w_tnext = T_W'(T_MAX);
        else                          w_tnext = T_W'(w_tsum);
    end

    // A hit is a signed compare, so a point inside a surface counts too.
    assign w_near = (r_best < $signed(DIST_W'({1'b0, r_surf_thr})));

    assign w_sqrt_start = (r_state == S_ACC) && (r_idx == 2'd2);
    assign w_sqrt_in    = r_acc + r_prod[SQ_W-1:0];

    sdf_rm_sqrt #(
        .WIDTH(SQ_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_sqrt_start),
        .i_value(w_sqrt_in),
        .o_done (w_sqrt_done),
        .o_root (w_sqrt_root)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= STEP_W'(100);
            r_dist_limit <= TRAV_W'(3276800);
            r_surf_thr   <= THR_W'(66);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_STEP_LIMIT: r_step_limit <= i_cfg_data[STEP_W-1:0];
                REG_DIST_LIMIT: r_dist_limit <= i_cfg_data[TRAV_W-1:0];
                REG_SURF_THR:   r_surf_thr   <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (w_in_acc) r_state <= S_CHK;
                S_CHK:  r_state <= (r_iter < r_step_limit) ? S_PMUL : S_OUT;
                S_PMUL: r_state <= S_PADD;
                S_PADD: r_state <= (r_idx == 2'd2) ? S_PREP : S_PMUL;
                S_PREP: r_state <= S_SQ;
                S_SQ:   r_state <= S_ACC;
                S_ACC:  r_state <= (r_idx == 2'd2) ? S_SQRT : S_SQ;
                S_SQRT: if (w_sqrt_done) r_state <= S_POST;
                S_POST: r_state <= (r_job == JOB_TUBE) ? S_UPD : S_SQ;
                S_UPD: begin
                    if (w_near) begin
                        r_state <= S_OUT;
                    end else if (w_tnext > T_W'({1'b0, r_dist_limit})) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_o[0] <= i_origin_x;
                r_o[1] <= i_origin_y;
                r_o[2] <= i_origin_z;
                r_d[0] <= i_dir_x;
                r_d[1] <= i_dir_y;
                r_d[2] <= i_dir_z;
                r_t    <= '0;
                r_iter <= '0;
                r_hit  <= 1'b0;
                r_idx  <= '0;
            end
            S_CHK: r_idx <= '0;
            S_PMUL: r_prod <= w_mul_a * w_mul_b;
            S_PADD: begin
                r_p[r_idx] <= w_psat;
                r_idx      <= (r_idx == 2'd2) ? 2'd0 : r_idx + 1'b1;
            end
            S_PREP: begin
                r_q[0] <= ((w_ax < 0) ? -w_ax : w_ax) - C_0P7;
                r_q[1] <= ((w_ay < 0) ? -w_ay : w_ay) - C_0P7;
                r_q[2] <= ((w_z < 0) ? -w_z : w_z) - C_0P7;
                r_rx   <= w_x + C_2P5;
                r_ry   <= w_y + C_0P8;
                r_best <= w_y + C_1P5;
                r_mat  <= MAT_W'(0);
                r_job  <= JOB_SPHERE;
                r_acc  <= '0;
                r_idx  <= '0;
            end
            S_SQ: r_prod <= w_mul_a * w_mul_b;
            S_ACC: begin
                r_acc <= w_sqrt_in;
                r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 1'b1;
            end
            S_POST: begin
                if (r_job == JOB_RING) begin
                    r_ring <= w_dist;
                end else if (w_dist < r_best) begin
                    r_best <= w_dist;
                    r_mat  <= MAT_W'(r_job) + ((r_job == JOB_TUBE) ? 2'd0 : 2'd1);
                end
                r_job <= t_job'(r_job + 2'd1);
                r_acc <= '0;
                r_idx <= '0;
            end
            S_UPD: begin
                if (w_near) begin
                    r_hit <= 1'b1;
                end else begin
                    r_t    <= w_tnext;
                    r_iter <= r_iter + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Result transaction into the output register.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_out_valid || i_out_ready)) begin
            r_out_hit    <= r_hit;
            r_out_travel <= r_hit ? r_t[TRAV_W-1:0] : '0;
            r_out_p[0]   <= r_hit ? r_p[0] : r_o[0];
            r_out_p[1]   <= r_hit ? r_p[1] : r_o[1];
            r_out_p[2]   <= r_hit ? r_p[2] : r_o[2];
            r_out_mat    <= r_hit ? r_mat : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_travel    = r_out_travel;
    assign o_point_x   = r_out_p[0];
    assign o_point_y   = r_out_p[1];
    assign o_point_z   = r_out_p[2];
    assign o_material  = r_out_mat;

    // The square root finishes only while the sequencer waits for it.
    a_sqrt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_done |-> (r_state == S_SQRT))
        else $error("square root finished outside its wait state");

    // A miss transaction carries zero travel and the ground material.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_travel == '0 && o_material == '0))
        else $error("miss result with nonzero travel or material");

    // An accepted ray starts with the step limit check.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_CHK))
        else $error("accepted ray did not start marching");

    // The operand index stays within the three axes.
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ || r_state == S_ACC || r_state == S_PMUL || r_state == S_PADD)
        |-> (r_idx != 2'd3))
        else $error("operand index out of range");

endmodule
`default_nettype wire

// ===== design/sdf_rm_sqrt.sv =====
`default_nettype none
module sdf_rm_sqrt #(
    parameter int WIDTH = sdf_rm_pkg::SQ_W
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [WIDTH-1:0]   i_value,
    output logic                    o_done,
    output logic [WIDTH/2-1:0]      o_root
);
    import sdf_rm_pkg::*;

    localparam int ITER  = WIDTH / 2;
    localparam int CNT_W = (ITER > 1) ? $clog2(ITER) : 1;

    logic [WIDTH-1:0] r_v;
    logic [WIDTH-1:0] r_r;
    logic [WIDTH-1:0] r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   w_trial;
    logic             w_take;

    // One result bit per cycle: trial subtract of root plus bit.
    assign w_trial = {1'b0, r_r} + {1'b0, r_b};
    assign w_take  = ({1'b0, r_v} >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Datapath of the digit recurrence.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_value;
            r_r <= '0;
            r_b <= {2'b01, {(WIDTH-2){1'b0}}};
        end else if (r_busy) begin
            if (w_take) begin
                r_v <= r_v - w_trial[WIDTH-1:0];
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[WIDTH/2-1:0];

endmodule
`default_nettype wire
